### design/psof_pkg.sv
package psof_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam int SIDE_W       = 7;
  localparam int COORD_W      = 6;
  localparam int COUNT_W      = 13;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  typedef enum logic [1:0] {
    CELL_CLOSED = 2'd0,
    CELL_OPEN   = 2'd1,
    CELL_WET    = 2'd2
  } cell_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    GA_CLR  = 2'd0,
    GA_SITE = 2'd1,
    GA_NB   = 2'd2,
    GA_SCAN = 2'd3
  } gaddr_t;

  typedef struct packed {
    logic   load;
    logic   clr_start;
    logic   clr_step;
    logic   grd;
    logic   gwr;
    gaddr_t asel;
    cell_t  gwdata;
    logic   count_inc;
    logic   push;
    logic   set_wet;
    logic   set_already;
    logic   dir_clr;
    logic   dir_inc;
    logic   pop;
    logic   pop_load;
    logic   scan_inc;
    logic   bottom_set;
    logic   bottom_val;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic oor;
    logic rd_closed;
    logic rd_open;
    logic rd_wet;
    logic top_row;
    logic nb_ok;
    logic dir_last;
    logic sp_zero;
    logic side_zero;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

### design/psof_ctrl.sv
module psof_ctrl import psof_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_CLR    = 13'b0000000000100,
    S_SITE   = 13'b0000000001000,
    S_NB_RD  = 13'b0000000010000,
    S_NB_CHK = 13'b0000000100000,
    S_POP    = 13'b0000001000000,
    S_POPW   = 13'b0000010000000,
    S_F_RD   = 13'b0000100000000,
    S_F_CHK  = 13'b0001000000000,
    S_SC_RD  = 13'b0010000000000,
    S_SC_CHK = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   boot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_CLR && sts.clr_last) boot <= 1'b0;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.func) begin
          cmd.clr_start = 1'b1;
          state_next    = S_CLR;
        end else if (sts.oor) begin
          state_next = S_SC_RD;
        end else begin
          cmd.grd    = 1'b1;
          cmd.asel   = GA_SITE;
          state_next = S_SITE;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.gwr      = 1'b1;
        cmd.asel     = GA_CLR;
        cmd.gwdata   = CELL_CLOSED;
        if (sts.clr_last) state_next = boot ? S_IDLE : S_DONE;
      end
      S_SITE: begin
        if (!sts.rd_closed) begin
          cmd.set_already = 1'b1;
          state_next      = S_SC_RD;
        end else if (sts.top_row) begin
          cmd.count_inc = 1'b1;
          cmd.gwr       = 1'b1;
          cmd.asel      = GA_SITE;
          cmd.gwdata    = CELL_WET;
          cmd.push      = 1'b1;
          cmd.set_wet   = 1'b1;
          state_next    = S_POP;
        end else begin
          cmd.count_inc = 1'b1;
          cmd.gwr       = 1'b1;
          cmd.asel      = GA_SITE;
          cmd.gwdata    = CELL_OPEN;
          cmd.dir_clr   = 1'b1;
          state_next    = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (sts.nb_ok) begin
          cmd.grd    = 1'b1;
          cmd.asel   = GA_NB;
          state_next = S_NB_CHK;
        end else if (sts.dir_last) begin
          state_next = S_SC_RD;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_NB_CHK: begin
        if (sts.rd_wet) begin
          cmd.gwr     = 1'b1;
          cmd.asel    = GA_SITE;
          cmd.gwdata  = CELL_WET;
          cmd.push    = 1'b1;
          cmd.set_wet = 1'b1;
          state_next  = S_POP;
        end else if (sts.dir_last) begin
          state_next = S_SC_RD;
        end else begin
          cmd.dir_inc = 1'b1;
          state_next  = S_NB_RD;
        end
      end
      S_POP: begin
        if (sts.sp_zero) begin
          state_next = S_SC_RD;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        cmd.dir_clr  = 1'b1;
        state_next   = S_F_RD;
      end
      S_F_RD: begin
        if (sts.nb_ok) begin
          cmd.grd    = 1'b1;
          cmd.asel   = GA_NB;
          state_next = S_F_CHK;
        end else if (sts.dir_last) begin
          state_next = S_POP;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_F_CHK: begin
        if (sts.rd_open) begin
          cmd.gwr    = 1'b1;
          cmd.asel   = GA_NB;
          cmd.gwdata = CELL_WET;
          cmd.push   = 1'b1;
        end
        if (sts.dir_last) begin
          state_next = S_POP;
        end else begin
          cmd.dir_inc = 1'b1;
          state_next  = S_F_RD;
        end
      end
      S_SC_RD: begin
        if (sts.side_zero) begin
          cmd.bottom_set = 1'b1;
          cmd.bottom_val = 1'b0;
          state_next     = S_DONE;
        end else begin
          cmd.grd    = 1'b1;
          cmd.asel   = GA_SCAN;
          state_next = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (sts.rd_wet) begin
          cmd.bottom_set = 1'b1;
          cmd.bottom_val = 1'b1;
          state_next     = S_DONE;
        end else if (sts.scan_last) begin
          cmd.bottom_set = 1'b1;
          cmd.bottom_val = 1'b0;
          state_next     = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SC_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/psof_dp.sv
module psof_dp import psof_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [SIDE_W-1:0]  cfg_data,
  input  logic               func,
  input  logic [COORD_W-1:0] site_row,
  input  logic [COORD_W-1:0] site_col,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               percolates,
  output logic [COUNT_W-1:0] open_count,
  output logic               already_open,
  output logic               site_wet,
  output logic               out_of_range
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 2 ** AW;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CMPW  = (SW > SIDE_W) ? SW : SIDE_W;

  logic [SIDE_W-1:0] grid_side;
  logic              func_q;
  logic              oor;
  logic [CW-1:0]     row_q, col_q, ctr_r, ctr_c, scol;
  logic [SW-1:0]     side_q;
  dir_t              dir;
  logic [AW:0]       sp;
  logic [AW-1:0]     clr_addr;
  logic [COUNT_W-1:0] opened_total;
  logic              bottom_wet, already, wet;

  logic [1:0]        gmem [DEPTH];
  logic [1:0]        grdata;
  logic [AW-1:0]     smem [DEPTH];
  logic [AW-1:0]     srdata;

  logic [CMPW-1:0]   side_eff;
  logic [CW-1:0]     nb_r, nb_c;
  logic              nb_ok;
  logic [AW-1:0]     gaddr;

  always_comb begin
    if (CMPW'(grid_side) > CMPW'(MAX_SIDE)) side_eff = CMPW'(MAX_SIDE);
    else side_eff = CMPW'(grid_side);
  end

  always_comb begin
    nb_r  = ctr_r;
    nb_c  = ctr_c;
    nb_ok = 1'b0;
    case (dir)
      DIR_UP: begin
        nb_r  = ctr_r - CW'(1);
        nb_ok = (ctr_r != '0);
      end
      DIR_LEFT: begin
        nb_c  = ctr_c - CW'(1);
        nb_ok = (ctr_c != '0);
      end
      DIR_RIGHT: begin
        nb_c  = ctr_c + CW'(1);
        nb_ok = (SW'(ctr_c) + SW'(1) < side_q);
      end
      default: begin
        nb_r  = ctr_r + CW'(1);
        nb_ok = (SW'(ctr_r) + SW'(1) < side_q);
      end
    endcase
  end

  always_comb begin
    case (cmd.asel)
      GA_CLR:  gaddr = clr_addr;
      GA_SITE: gaddr = {row_q, col_q};
      GA_NB:   gaddr = {nb_r, nb_c};
      default: gaddr = {CW'(side_q - SW'(1)), scol};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.gwr) gmem[gaddr] <= cmd.gwdata;
    if (cmd.grd) grdata <= gmem[gaddr];
    if (cmd.push) smem[sp[AW-1:0]] <= gaddr;
    if (cmd.pop) srdata <= smem[AW'(sp - (AW+1)'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side    <= SIDE_RESET;
      clr_addr     <= '0;
      sp           <= '0;
      opened_total <= '0;
      bottom_wet   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) grid_side <= cfg_data;
      if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
      if (cmd.clr_start) begin
        opened_total <= '0;
        bottom_wet   <= 1'b0;
      end
      if (cmd.count_inc) opened_total <= opened_total + COUNT_W'(1);
      if (cmd.load) sp <= '0;
      else if (cmd.push) sp <= sp + (AW+1)'(1);
      else if (cmd.pop) sp <= sp - (AW+1)'(1);
      if (cmd.bottom_set) bottom_wet <= cmd.bottom_val;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      row_q   <= CW'(site_row);
      col_q   <= CW'(site_col);
      ctr_r   <= CW'(site_row);
      ctr_c   <= CW'(site_col);
      side_q  <= SW'(side_eff);
      oor     <= func && (CMPW'(site_row) >= side_eff || CMPW'(site_col) >= side_eff);
      scol    <= '0;
      already <= 1'b0;
      wet     <= 1'b0;
    end
    if (cmd.pop_load) begin
      ctr_r <= srdata[AW-1:CW];
      ctr_c <= srdata[CW-1:0];
    end
    if (cmd.dir_clr) dir <= DIR_UP;
    else if (cmd.dir_inc) dir <= dir_t'(dir + 2'd1);
    if (cmd.scan_inc) scol <= scol + CW'(1);
    if (cmd.set_wet) wet <= 1'b1;
    if (cmd.set_already) begin
      already <= 1'b1;
      wet     <= (grdata == CELL_WET);
    end
    if (cmd.out_load) begin
      percolates   <= bottom_wet;
      open_count   <= opened_total;
      already_open <= already;
      site_wet     <= wet;
      out_of_range <= oor;
    end
  end

  always_comb begin
    sts.func      = func_q;
    sts.oor       = oor;
    sts.rd_closed = (grdata == CELL_CLOSED);
    sts.rd_open   = (grdata == CELL_OPEN);
    sts.rd_wet    = (grdata == CELL_WET);
    sts.top_row   = (row_q == '0);
    sts.nb_ok     = nb_ok;
    sts.dir_last  = (dir == DIR_DOWN);
    sts.sp_zero   = (sp == '0);
    sts.side_zero = (side_q == '0);
    sts.scan_last = (SW'(scol) + SW'(1) >= side_q);
    sts.clr_last  = (&clr_addr);
    sts.out_free  = !out_valid || out_ready;
  end

  a_push_wets: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> cmd.gwr && cmd.gwdata == CELL_WET)
    else $error("push without wetting the cell");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> sp != '0)
    else $error("pop on empty stack");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("result overwritten");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (AW+1)'(DEPTH))
    else $error("stack overflow");

endmodule

### design/percolation_site_open_fill_core.sv
// Site percolation flood-fill core.
// Input channel (in_valid/in_ready) carries func, site_row, site_col:
// func 0 clears the grid, func 1 opens one site. One result item per
// input item on the output channel (out_valid/out_ready).
// cfg_write/cfg_data set grid_side (reset 64); the user must write it only
// while the core is idle, which the core itself does not enforce. The core
// works on one item at a time, driven by a controller over a single-port
// grid RAM (one read or write per cycle) and a stack RAM. An out-of-range
// or already-open site goes straight to the bottom-row scan. A new site is
// opened; on the top row or next to a wet cell it is wetted, and the flood
// pops wetted cells from the stack and wets their open neighbours. The
// bottom-row scan checks one column at a time and stops at the first wet
// cell. Clear writes every grid word closed (one grid word per cycle).
// After reset the core clears the grid with in_ready low, and sends no
// result for it.
// A finished result sits in an output register; a next item is taken while
// it waits, and that item's result holds until the register is free.
module percolation_site_open_fill_core import psof_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [SIDE_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [COORD_W-1:0] site_row,
  input  logic [COORD_W-1:0] site_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               percolates,
  output logic [COUNT_W-1:0] open_count,
  output logic               already_open,
  output logic               site_wet,
  output logic               out_of_range
);

  cmd_t cmd;
  sts_t sts;

  psof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psof_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .func         (func),
    .site_row     (site_row),
    .site_col     (site_col),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .percolates   (percolates),
    .open_count   (open_count),
    .already_open (already_open),
    .site_wet     (site_wet),
    .out_of_range (out_of_range)
  );

endmodule
